>>> rtl/vfv_pkg.sv
// ----------------------------------------------------------------------------
// vfv_pkg
// shared beat types, command codes and face bit positions for the voxel face
// visibility block
// ----------------------------------------------------------------------------
package vfv_pkg;

    // command codes
    localparam logic [1:0] CMD_WRITE_VOXEL = 2'd0;
    localparam logic [1:0] CMD_WRITE_EDGE  = 2'd1;
    localparam logic [1:0] CMD_QUERY       = 2'd2;

    // face bit positions in the mask
    localparam int FACE_COUNT = 6;
    localparam logic [2:0] FACE_NORTH  = 3'd0;
    localparam logic [2:0] FACE_SOUTH  = 3'd1;
    localparam logic [2:0] FACE_WEST   = 3'd2;
    localparam logic [2:0] FACE_EAST   = 3'd3;
    localparam logic [2:0] FACE_BOTTOM = 3'd4;
    localparam logic [2:0] FACE_TOP    = 3'd5;

    // work queue between front and back, power of two deep
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PW    = 2;

    typedef struct packed {
        logic [1:0] command;
        logic [3:0] pos_x;
        logic [3:0] pos_y;
        logic [3:0] pos_z;
        logic [7:0] block_value;
    } in_item_t;

    typedef struct packed {
        logic [5:0] face_mask;
        logic [7:0] block_type;
    } out_item_t;

    // classified work item; bound marks faces at the chunk boundary
    // (for north it means z is zero and the neighbour slice is used)
    typedef struct packed {
        logic [1:0]            op;
        logic [3:0]            pos_x;
        logic [3:0]            pos_y;
        logic [3:0]            pos_z;
        logic [7:0]            value;
        logic [FACE_COUNT-1:0] bound;
    } work_t;

endpackage

>>> rtl/vfv_ram.sv
// ----------------------------------------------------------------------------
// vfv_ram
// generic single-port ram with registered read data
// ----------------------------------------------------------------------------
module vfv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem_reg[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem_reg[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/vfv_queue.sv
// ----------------------------------------------------------------------------
// vfv_queue
// short work queue between the classifying front and the executing back
// ----------------------------------------------------------------------------
module vfv_queue import vfv_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  work_t push_data,
    output logic  full,
    input  logic  pop,
    output work_t head,
    output logic  not_empty
);

    work_t               entries_reg [QUEUE_DEPTH];
    logic [QUEUE_PW-1:0] wptr_reg, wptr_next;
    logic [QUEUE_PW-1:0] rptr_reg, rptr_next;
    logic [QUEUE_PW:0]   count_reg, count_next;
    logic                do_push, do_pop;

    assign full      = (count_reg == (QUEUE_PW+1)'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = entries_reg[rptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wptr_next  = do_push ? wptr_reg + 1'b1 : wptr_reg;
        rptr_next  = do_pop ? rptr_reg + 1'b1 : rptr_reg;
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wptr_reg] <= push_data;
        end
    end

endmodule

>>> rtl/vfv_front.sv
// ----------------------------------------------------------------------------
// vfv_front
// takes input beats, drops unused commands and out-of-chunk coordinates,
// marks boundary faces and hands the rest to the work queue
// ----------------------------------------------------------------------------
module vfv_front import vfv_pkg::*; #(
    parameter int EDGE_SIZE     = 16,
    parameter int COLUMN_HEIGHT = 16
) (
    input  logic     in_valid,
    output logic     in_ready,
    input  in_item_t in_data,
    output logic     q_push,
    output work_t    q_data,
    input  logic     q_full
);

    logic xy_ok, z_ok, keep;

    assign xy_ok = (32'(in_data.pos_x) < 32'(EDGE_SIZE))
                && (32'(in_data.pos_y) < 32'(COLUMN_HEIGHT));
    assign z_ok  = (32'(in_data.pos_z) < 32'(EDGE_SIZE));

    always_comb
    begin
        unique case (in_data.command)
            CMD_WRITE_VOXEL: keep = xy_ok && z_ok;
            CMD_WRITE_EDGE:  keep = xy_ok;
            CMD_QUERY:       keep = xy_ok && z_ok;
            default:         keep = 1'b0;
        endcase
    end

    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full && keep;

    always_comb
    begin
        q_data.op    = in_data.command;
        q_data.pos_x = in_data.pos_x;
        q_data.pos_y = in_data.pos_y;
        q_data.pos_z = in_data.pos_z;
        q_data.value = in_data.block_value;
        q_data.bound = '0;
        q_data.bound[FACE_NORTH]  = (in_data.pos_z == '0);
        q_data.bound[FACE_SOUTH]  = (32'(in_data.pos_z) >= 32'(EDGE_SIZE - 1));
        q_data.bound[FACE_WEST]   = (in_data.pos_x == '0);
        q_data.bound[FACE_EAST]   = (32'(in_data.pos_x) >= 32'(EDGE_SIZE - 1));
        q_data.bound[FACE_BOTTOM] = (in_data.pos_y == '0);
        q_data.bound[FACE_TOP]    = (32'(in_data.pos_y) >= 32'(COLUMN_HEIGHT - 1));
    end

endmodule

>>> rtl/vfv_back.sv
// ----------------------------------------------------------------------------
// vfv_back
// executes queued work: writes go straight to the stores, a query reads the
// voxel and its six neighbours one per cycle and builds the face mask
// ----------------------------------------------------------------------------
module vfv_back import vfv_pkg::*; #(
    parameter int EDGE_SIZE     = 16,
    parameter int COLUMN_HEIGHT = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic [7:0] air_code,
    input  logic      q_valid,
    input  work_t     q_head,
    output logic      q_pop,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    localparam int SLICE      = EDGE_SIZE * COLUMN_HEIGHT;
    localparam int VOX_DEPTH  = EDGE_SIZE * EDGE_SIZE * COLUMN_HEIGHT;
    localparam int VOX_AW     = $clog2(VOX_DEPTH);
    localparam int EDGE_DEPTH = SLICE;
    localparam int EDGE_AW    = $clog2(EDGE_DEPTH);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_READ = 1'b1;

    localparam logic [2:0] STEP_FIRST = 3'd1;
    localparam logic [2:0] STEP_BLOCK = 3'd1;
    localparam logic [2:0] STEP_LAST  = 3'd7;

    logic                  state_reg, state_next;
    logic [2:0]            step_reg, step_next;
    logic [VOX_AW-1:0]     base_reg, base_next;
    logic [FACE_COUNT-1:0] bound_reg, bound_next;
    logic [FACE_COUNT-1:0] mask_reg, mask_next;
    logic [7:0]            blk_reg, blk_next;
    logic                  out_valid_reg, out_valid_next;
    out_item_t             out_data_reg, out_data_next;

    logic                  pop, head_query, out_free, load;
    logic [VOX_AW-1:0]     head_addr, nb_addr, vox_addr;
    logic [EDGE_AW-1:0]    edge_addr;
    logic                  vox_en, vox_we, edge_en, edge_we;
    logic [7:0]            vox_rdata, edge_rdata;
    logic [2:0]            face_idx;
    logic                  face_bit;
    logic [FACE_COUNT-1:0] mask_with;

    assign pop        = (state_reg == ST_IDLE) && q_valid;
    assign q_pop      = pop;
    assign head_query = (q_head.op == CMD_QUERY);
    assign out_free   = !out_valid_reg || out_ready;
    assign load       = (state_reg == ST_READ) && (step_reg == STEP_LAST) && out_free;

    assign head_addr = VOX_AW'(q_head.pos_x)
                     + VOX_AW'(q_head.pos_y) * VOX_AW'(EDGE_SIZE)
                     + VOX_AW'(q_head.pos_z) * VOX_AW'(SLICE);
    assign edge_addr = EDGE_AW'(q_head.pos_x)
                     + EDGE_AW'(q_head.pos_y) * EDGE_AW'(EDGE_SIZE);

    // neighbour to read at each step; at a boundary the centre is re-read
    always_comb
    begin
        unique case (step_reg)
            3'd1:    nb_addr = bound_reg[FACE_NORTH]  ? base_reg : base_reg - VOX_AW'(SLICE);
            3'd2:    nb_addr = bound_reg[FACE_SOUTH]  ? base_reg : base_reg + VOX_AW'(SLICE);
            3'd3:    nb_addr = bound_reg[FACE_WEST]   ? base_reg : base_reg - 1'b1;
            3'd4:    nb_addr = bound_reg[FACE_EAST]   ? base_reg : base_reg + 1'b1;
            3'd5:    nb_addr = bound_reg[FACE_BOTTOM] ? base_reg
                                                      : base_reg - VOX_AW'(EDGE_SIZE);
            3'd6:    nb_addr = bound_reg[FACE_TOP]    ? base_reg
                                                      : base_reg + VOX_AW'(EDGE_SIZE);
            default: nb_addr = base_reg;
        endcase
    end

    assign vox_en   = (pop && (q_head.op == CMD_WRITE_VOXEL || head_query))
                   || (state_reg == ST_READ && step_reg != STEP_LAST);
    assign vox_we   = pop && (q_head.op == CMD_WRITE_VOXEL);
    assign vox_addr = (state_reg == ST_IDLE) ? head_addr : nb_addr;
    assign edge_en  = pop && (q_head.op == CMD_WRITE_EDGE || head_query);
    assign edge_we  = pop && (q_head.op == CMD_WRITE_EDGE);

    vfv_ram #(
        .WIDTH (8),
        .DEPTH (VOX_DEPTH)
    ) u_voxel_ram (
        .clk   (clk),
        .en    (vox_en),
        .we    (vox_we),
        .addr  (vox_addr),
        .wdata (q_head.value),
        .rdata (vox_rdata)
    );

    vfv_ram #(
        .WIDTH (8),
        .DEPTH (EDGE_DEPTH)
    ) u_edge_ram (
        .clk   (clk),
        .en    (edge_en),
        .we    (edge_we),
        .addr  (edge_addr),
        .wdata (q_head.value),
        .rdata (edge_rdata)
    );

    // read data at step s belongs to face s-2
    assign face_idx = step_reg - 3'd2;

    always_comb
    begin
        face_bit  = 1'b0;
        mask_with = mask_reg;
        if (step_reg > STEP_BLOCK)
        begin
            if (bound_reg[face_idx])
            begin
                face_bit = (face_idx == FACE_NORTH) ? (edge_rdata == air_code) : 1'b1;
            end
            else
            begin
                face_bit = (vox_rdata == air_code);
            end
            mask_with[face_idx] = face_bit;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        base_next      = base_reg;
        bound_next     = bound_reg;
        mask_next      = mask_reg;
        blk_next       = blk_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (pop && head_query)
                begin
                    state_next = ST_READ;
                    step_next  = STEP_FIRST;
                    base_next  = head_addr;
                    bound_next = q_head.bound;
                    mask_next  = '0;
                end
            end
            ST_READ:
            begin
                if (step_reg != STEP_LAST)
                begin
                    step_next = step_reg + 1'b1;
                    if (step_reg == STEP_BLOCK)
                    begin
                        blk_next = vox_rdata;
                    end
                    else
                    begin
                        mask_next = mask_with;
                    end
                end
                else if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (load)
        begin
            out_valid_next           = 1'b1;
            out_data_next.face_mask  = mask_with;
            out_data_next.block_type = blk_reg;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg     <= base_next;
        bound_reg    <= bound_next;
        mask_reg     <= mask_next;
        blk_reg      <= blk_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // stores are never written while a query is reading them
    a_no_write_in_query: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |-> (!vox_we && !edge_en))
        else $error("store access during query read");

    // a popped query starts its neighbour reads in the next cycle
    a_query_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && head_query) |=> (state_reg == ST_READ && step_reg == STEP_FIRST))
        else $error("query did not start reading");

    // a finished query waits while the output register is still taken
    a_result_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ && step_reg == STEP_LAST && !out_free)
        |=> (state_reg == ST_READ && step_reg == STEP_LAST && out_valid_reg))
        else $error("finished query lost while output busy");

    // the read sequencer never sits on an unused step
    a_step_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |-> (step_reg != 3'd0))
        else $error("read step out of range");

endmodule

>>> rtl/voxel_face_visibility_mask_top.sv
// ----------------------------------------------------------------------------
// voxel_face_visibility_mask_top
// holds one voxel chunk and its north neighbour slice and answers queries
// with the block type of a voxel and the mask of its exposed faces. Input
// beats carry a command: chunk voxel writes and north slice writes give no
// result; a query reads the voxel and its six neighbours through the
// single port of the voxel memory, one read per cycle, and its result then
// stands in the output register. Unused commands and coordinates outside
// the chunk are dropped at the front without a result. The front accepts
// beats whenever the four-entry work queue has room, so writes and further
// queries keep arriving while a query is being read out or its result waits
// for the consumer. A face counts as exposed when the neighbour holds the
// air code; at z zero the north neighbour comes from the slice store, and
// the other five faces are exposed at the chunk boundary. The stores have no
// reset and no clearing pass: only entries already written may be read.
// The air code register is written through cfg_we / cfg_wdata; the user
// must write it only while idle, as the block does not enforce this.
// ----------------------------------------------------------------------------
module voxel_face_visibility_mask_top import vfv_pkg::*; #(
    parameter int EDGE_SIZE     = 16,
    parameter int COLUMN_HEIGHT = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  in_item_t   in_data,
    output logic       out_valid,
    input  logic       out_ready,
    output out_item_t  out_data,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata
);

    // air code register, reset to zero
    logic [7:0] air_code_reg, air_code_next;

    // front to queue
    logic  q_push;
    work_t q_push_data;
    logic  q_full;

    // queue to back
    logic  q_pop;
    work_t q_head;
    logic  q_not_empty;

    assign air_code_next = cfg_we ? cfg_wdata : air_code_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            air_code_reg <= '0;
        end
        else
        begin
            air_code_reg <= air_code_next;
        end
    end

    // classify each input beat and mark its boundary faces
    vfv_front #(
        .EDGE_SIZE     (EDGE_SIZE),
        .COLUMN_HEIGHT (COLUMN_HEIGHT)
    ) u_front (
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .q_push   (q_push),
        .q_data   (q_push_data),
        .q_full   (q_full)
    );

    // decouples the front from the read sequencer
    vfv_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .head      (q_head),
        .not_empty (q_not_empty)
    );

    // stores, read sequencer and output register
    vfv_back #(
        .EDGE_SIZE     (EDGE_SIZE),
        .COLUMN_HEIGHT (COLUMN_HEIGHT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .air_code  (air_code_reg),
        .q_valid   (q_not_empty),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

>>> verif/tb_voxel_face_visibility_mask_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_voxel_face_visibility_mask_top
// self-checking bench for the voxel face visibility block: a queue of command
// beats feeds a falling-edge driver, a rising-edge monitor keeps its own image
// of the chunk, the north slice and the air code, and checks every answer
// field by field, with random idling on both sides and several air settings
// ----------------------------------------------------------------------------
module tb_voxel_face_visibility_mask_top;
    import vfv_pkg::*;

    localparam int EDGE_SIZE     = 16;
    localparam int COLUMN_HEIGHT = 16;
    localparam int SLICE_SIZE    = EDGE_SIZE * COLUMN_HEIGHT;
    localparam int CHUNK_VOXELS  = SLICE_SIZE * EDGE_SIZE;

    // command code the block has no use for
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // random beats per air setting, and the number of air settings
    localparam int PHASE_BEATS = 310;
    localparam int PHASES      = 5;
    // quiet cycles after the last answer, covers writes still in the queue
    localparam int TAIL_CYCLES = 48;
    localparam int CYCLE_LIMIT = 600000;

    // ------------------------------------------------------------------------
    // clock, reset and block inputs, all known from time zero
    // ------------------------------------------------------------------------
    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    in_item_t   in_data   = '0;
    logic       out_ready = 1'b0;
    logic       cfg_we    = 1'b0;
    logic [7:0] cfg_wdata = 8'h00;
    logic       in_ready;
    logic       out_valid;
    out_item_t  out_data;

    initial
    begin
        forever #2 clk = ~clk;
    end

    voxel_face_visibility_mask_top #(
        .EDGE_SIZE     (EDGE_SIZE),
        .COLUMN_HEIGHT (COLUMN_HEIGHT)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // ------------------------------------------------------------------------
    // bench state
    // ------------------------------------------------------------------------
    // beats waiting to be driven, filled ahead of time by the stimulus block
    in_item_t   cmd_feed [$];
    // answers owed by the block, oldest first
    out_item_t  due_answers [$];
    out_item_t  answer_head;

    // predictor's own copy of the stores and the air register
    logic [7:0] chunk_img [CHUNK_VOXELS];
    logic [7:0] edge_img [SLICE_SIZE];
    logic [7:0] air_model = 8'h00;

    // what the stimulus has already written, so no unwritten entry is read
    bit         vox_set [CHUNK_VOXELS];
    bit         edge_set [SLICE_SIZE];
    logic [7:0] gen_air = 8'h00;
    int         staged_count = 0;

    // handshakes seen at the last rising edge, used by the falling-edge sides
    bit         in_took  = 1'b0;
    bit         out_took = 1'b0;
    int         send_gap = 0;
    int         rcv_stall = 0;
    bit         send_burst = 1'b0;
    bit         rcv_burst = 1'b0;

    int         fail_count = 0;
    int         beats_taken = 0;
    int         answers_checked = 0;
    int         air_settings = 1;
    int         cycle_count = 0;
    bit         masks_seen [64];

    // ------------------------------------------------------------------------
    // helpers
    // ------------------------------------------------------------------------
    function automatic int vox_addr(int x, int y, int z);
        return x + y * EDGE_SIZE + z * SLICE_SIZE;
    endfunction

    task automatic flag_mismatch(string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        fail_count++;
    endtask

    // idle cycles before the next beat; bursts with no idling come and go
    function automatic int idle_cycles(inout bit burst);
        if ($urandom_range(0, 39) == 0)
            burst = !burst;
        return burst ? 0 : $urandom_range(0, 18);
    endfunction

    // exposed faces and block type of one voxel, from the bench's images
    function automatic out_item_t face_answer(int x, int y, int z);
        out_item_t a;
        a.face_mask = '0;
        // north at z zero looks into the neighbour chunk's far slice
        if (z == 0)
            a.face_mask[FACE_NORTH] = (edge_img[x + y * EDGE_SIZE] == air_model);
        else
            a.face_mask[FACE_NORTH] = (chunk_img[vox_addr(x, y, z - 1)] == air_model);
        // the other five faces are open at the chunk boundary
        if (z == EDGE_SIZE - 1)
            a.face_mask[FACE_SOUTH] = 1'b1;
        else
            a.face_mask[FACE_SOUTH] = (chunk_img[vox_addr(x, y, z + 1)] == air_model);
        if (x == 0)
            a.face_mask[FACE_WEST] = 1'b1;
        else
            a.face_mask[FACE_WEST] = (chunk_img[vox_addr(x - 1, y, z)] == air_model);
        if (x == EDGE_SIZE - 1)
            a.face_mask[FACE_EAST] = 1'b1;
        else
            a.face_mask[FACE_EAST] = (chunk_img[vox_addr(x + 1, y, z)] == air_model);
        if (y == 0)
            a.face_mask[FACE_BOTTOM] = 1'b1;
        else
            a.face_mask[FACE_BOTTOM] = (chunk_img[vox_addr(x, y - 1, z)] == air_model);
        if (y == COLUMN_HEIGHT - 1)
            a.face_mask[FACE_TOP] = 1'b1;
        else
            a.face_mask[FACE_TOP] = (chunk_img[vox_addr(x, y + 1, z)] == air_model);
        a.block_type = chunk_img[vox_addr(x, y, z)];
        return a;
    endfunction

    // apply one accepted beat to the images, queue the answer it is owed
    function automatic void apply_command(in_item_t b);
        int x;
        int y;
        int z;
        bit xy_ok;
        x = int'(b.pos_x);
        y = int'(b.pos_y);
        z = int'(b.pos_z);
        xy_ok = (x < EDGE_SIZE) && (y < COLUMN_HEIGHT);
        case (b.command)
            CMD_WRITE_VOXEL:
                if (xy_ok && z < EDGE_SIZE)
                    chunk_img[vox_addr(x, y, z)] = b.block_value;
            CMD_WRITE_EDGE:
                // pos_z plays no part in a slice write
                if (xy_ok)
                    edge_img[x + y * EDGE_SIZE] = b.block_value;
            CMD_QUERY:
                if (xy_ok && z < EDGE_SIZE)
                    due_answers = {due_answers, face_answer(x, y, z)};
            default:
                ;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // stimulus building
    // ------------------------------------------------------------------------
    function automatic void push_item(logic [1:0] cmd, int x, int y, int z,
                                      logic [7:0] value);
        in_item_t b;
        b.command     = cmd;
        b.pos_x       = 4'(x);
        b.pos_y       = 4'(y);
        b.pos_z       = 4'(z);
        b.block_value = value;
        cmd_feed = {cmd_feed, b};
        if (cmd == CMD_WRITE_VOXEL)
            vox_set[vox_addr(x, y, z)] = 1'b1;
        else if (cmd == CMD_WRITE_EDGE)
            edge_set[x + y * EDGE_SIZE] = 1'b1;
        staged_count++;
    endfunction

    // block values lean on the current air code so masks vary
    function automatic logic [7:0] pick_block();
        if ($urandom_range(0, 99) < 45)
            return gen_air;
        return 8'($urandom_range(0, 255));
    endfunction

    // coordinates lean on the chunk faces
    function automatic int pick_coord(int span);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 25)
            return 0;
        if (roll < 50)
            return span - 1;
        return $urandom_range(0, span - 1);
    endfunction

    // write a cell if it was never written, and now and then anyway
    function automatic void stage_cell(int x, int y, int z);
        if (!vox_set[vox_addr(x, y, z)] || $urandom_range(0, 3) == 0)
            push_item(CMD_WRITE_VOXEL, x, y, z, pick_block());
    endfunction

    // a query preceded by whatever writes it needs to read only written cells
    function automatic void stage_query(int x, int y, int z);
        stage_cell(x, y, z);
        if (z == 0)
        begin
            if (!edge_set[x + y * EDGE_SIZE] || $urandom_range(0, 3) == 0)
                push_item(CMD_WRITE_EDGE, x, y, $urandom_range(0, 15), pick_block());
        end
        else
            stage_cell(x, y, z - 1);
        if (z < EDGE_SIZE - 1)
            stage_cell(x, y, z + 1);
        if (x > 0)
            stage_cell(x - 1, y, z);
        if (x < EDGE_SIZE - 1)
            stage_cell(x + 1, y, z);
        if (y > 0)
            stage_cell(x, y - 1, z);
        if (y < COLUMN_HEIGHT - 1)
            stage_cell(x, y + 1, z);
        push_item(CMD_QUERY, x, y, z, 8'($urandom_range(0, 255)));
    endfunction

    // hold until everything sent has been answered, then let writes settle
    task automatic drain_results();
        while (cmd_feed.size() != 0 || in_valid || due_answers.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // driver: changes at the falling edge, one beat at a time from the feed
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_took)
        begin
            // a fresh gap is drawn after every accepted beat
            if (in_took)
                send_gap = idle_cycles(send_burst);
            if (send_gap > 0)
            begin
                send_gap--;
                in_valid <= 1'b0;
            end
            else if (cmd_feed.size() != 0)
            begin
                in_data  <= cmd_feed.pop_front();
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // receiver: stalls a drawn number of cycles after each answer beat
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_took)
                rcv_stall = idle_cycles(rcv_burst);
            if (rcv_stall > 0)
            begin
                rcv_stall--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // monitor: samples at the rising edge, before the block's own updates
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        in_took  = in_valid && in_ready;
        out_took = out_valid && out_ready;
        if (rst_n)
        begin
            // air code only changes while the block is idle
            if (cfg_we)
            begin
                air_model = cfg_wdata;
                air_settings++;
            end
            if (out_took)
            begin
                if (due_answers.size() == 0)
                    flag_mismatch($sformatf("answer with no query outstanding: mask %02h type %02h",
                                            out_data.face_mask, out_data.block_type));
                else
                begin
                    answer_head = due_answers.pop_front();
                    if (out_data.face_mask !== answer_head.face_mask)
                        flag_mismatch($sformatf("face_mask got %02h want %02h",
                                                out_data.face_mask, answer_head.face_mask));
                    if (out_data.block_type !== answer_head.block_type)
                        flag_mismatch($sformatf("block_type got %02h want %02h",
                                                out_data.block_type, answer_head.block_type));
                    masks_seen[answer_head.face_mask] = 1'b1;
                    answers_checked++;
                end
            end
            if (in_took)
            begin
                apply_command(in_data);
                beats_taken++;
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d answers outstanding",
                     cycle_count, due_answers.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus: directed corner cases, then random phases under several air
    // codes, the register rewritten only between phases once idle
    // ------------------------------------------------------------------------
    initial
    begin
        int ph;
        int start_count;
        int roll;
        int seen;
        logic [7:0] next_air;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // low corner: north taken from the neighbour slice, which holds air
        push_item(CMD_WRITE_EDGE, 0, 0, 9, 8'h00);
        push_item(CMD_WRITE_VOXEL, 0, 0, 0, 8'hFF);
        push_item(CMD_WRITE_VOXEL, 1, 0, 0, 8'h00);
        push_item(CMD_WRITE_VOXEL, 0, 1, 0, 8'h80);
        push_item(CMD_WRITE_VOXEL, 0, 0, 1, 8'h00);
        push_item(CMD_QUERY, 0, 0, 0, 8'hA5);
        // high corner: south, east and top open at the boundary
        push_item(CMD_WRITE_VOXEL, 15, 15, 15, 8'hAA);
        push_item(CMD_WRITE_VOXEL, 14, 15, 15, 8'h55);
        push_item(CMD_WRITE_VOXEL, 15, 14, 15, 8'h00);
        push_item(CMD_WRITE_VOXEL, 15, 15, 14, 8'hFF);
        push_item(CMD_QUERY, 15, 15, 15, 8'h5A);
        // slice write with z set, which must be ignored; queried voxel is air
        push_item(CMD_WRITE_EDGE, 15, 15, 15, 8'h01);
        push_item(CMD_WRITE_VOXEL, 15, 15, 0, 8'h00);
        push_item(CMD_WRITE_VOXEL, 14, 15, 0, 8'h01);
        push_item(CMD_WRITE_VOXEL, 15, 14, 0, 8'h00);
        push_item(CMD_WRITE_VOXEL, 15, 15, 1, 8'hFF);
        push_item(CMD_QUERY, 15, 15, 0, 8'hFF);
        // unused command with every field bit set gives no answer
        push_item(CMD_UNUSED, 15, 15, 15, 8'hFF);
        // an air voxel queried, then again after a neighbour is overwritten
        push_item(CMD_WRITE_VOXEL, 0, 0, 2, 8'h00);
        push_item(CMD_WRITE_VOXEL, 1, 0, 1, 8'hFF);
        push_item(CMD_WRITE_VOXEL, 0, 1, 1, 8'h00);
        push_item(CMD_QUERY, 0, 0, 1, 8'h00);
        push_item(CMD_WRITE_VOXEL, 0, 0, 0, 8'h00);
        push_item(CMD_QUERY, 0, 0, 1, 8'h3C);

        for (ph = 0; ph < PHASES; ph++)
        begin
            if (ph != 0)
            begin
                // sender holds off until every answer is back
                drain_results();
                case (ph)
                    1:       next_air = 8'hFF;
                    3:       next_air = 8'h00;
                    default: next_air = 8'($urandom_range(1, 254));
                endcase
                @(negedge clk);
                cfg_we    <= 1'b1;
                cfg_wdata <= next_air;
                @(negedge clk);
                cfg_we    <= 1'b0;
                gen_air = next_air;
            end
            // mostly well-formed query sequences, some loose writes and noise
            start_count = staged_count;
            while (staged_count - start_count < PHASE_BEATS)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 8)
                    push_item(CMD_UNUSED, $urandom_range(0, 15), $urandom_range(0, 15),
                              $urandom_range(0, 15), 8'($urandom_range(0, 255)));
                else if (roll < 22)
                    push_item(CMD_WRITE_VOXEL, pick_coord(EDGE_SIZE),
                              pick_coord(COLUMN_HEIGHT), pick_coord(EDGE_SIZE), pick_block());
                else if (roll < 30)
                    push_item(CMD_WRITE_EDGE, pick_coord(EDGE_SIZE),
                              pick_coord(COLUMN_HEIGHT), $urandom_range(0, 15), pick_block());
                else
                    stage_query(pick_coord(EDGE_SIZE), pick_coord(COLUMN_HEIGHT),
                                pick_coord(EDGE_SIZE));
            end
        end

        drain_results();

        seen = 0;
        for (int m = 0; m < 64; m++)
            if (masks_seen[m])
                seen++;
        $display("run covered %0d beats in, %0d answers checked, %0d air code settings",
                 beats_taken, answers_checked, air_settings);
        $display("%0d of 64 face mask values came up, %0d mismatches", seen, fail_count);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
